// ===== src/lsvm_pkg.sv =====
// shared types and constants for the linear svm sgd trainer
// no dependencies
package lsvm_pkg;

    localparam int MAX_FEATURES = 512;
    localparam int ADDR_W       = $clog2(MAX_FEATURES);
    localparam int CNT_W        = $clog2(MAX_FEATURES + 1);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FEATURE_COUNT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REGULARIZATION = 1'b1;

    localparam logic KIND_FEATURE = 1'b0;
    localparam logic KIND_READ    = 1'b1;
    localparam logic RES_SAMPLE   = 1'b0;
    localparam logic RES_WEIGHT   = 1'b1;

    localparam int DIV_REM_W  = 49;
    localparam int DIV_WORD_W = 64;
    localparam int DIV_CNT_W  = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_SCALE = 6'd32;
    localparam logic [DIV_CNT_W-1:0] DIV_STEPS_TERM  = 6'd36;

    typedef struct packed {
        logic               kind;
        logic [8:0]         feature_index;
        logic signed [15:0] feature_value;
        logic               label;
        logic               last_feature;
    } in_word_t;

    typedef struct packed {
        logic               result_kind;
        logic signed [31:0] weight_value;
        logic signed [31:0] margin;
        logic               hinge_active;
        logic [31:0]        samples_seen;
    } out_word_t;

    typedef struct packed {
        logic                  start;
        logic [DIV_CNT_W-1:0]  steps;
        logic [DIV_REM_W-1:0]  rem_init;
        logic [DIV_WORD_W-1:0] dividend;
        logic [DIV_REM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [DIV_WORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ===== src/lsvm_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on lsvm_pkg
module lsvm_div (
    input  logic              clk,
    input  logic              rst_n,
    input  lsvm_pkg::div_req_t req,
    output lsvm_pkg::div_rsp_t rsp
);

    logic [lsvm_pkg::DIV_REM_W-1:0]  rem_reg, rem_next;
    logic [lsvm_pkg::DIV_WORD_W-1:0] word_reg, word_next;
    logic [lsvm_pkg::DIV_REM_W-1:0]  divisor_reg, divisor_next;
    logic [lsvm_pkg::DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [lsvm_pkg::DIV_REM_W:0]    trial;
    logic [lsvm_pkg::DIV_REM_W:0]    diff;
    logic                            fits;

    assign trial = {rem_reg, word_reg[lsvm_pkg::DIV_WORD_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};
    assign fits  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        rem_next     = rem_reg;
        word_next    = word_reg;
        divisor_next = divisor_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        if (req.start)
        begin
            rem_next     = req.rem_init;
            word_next    = req.dividend;
            divisor_next = req.divisor;
            cnt_next     = req.steps;
            busy_next    = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = fits ? diff[lsvm_pkg::DIV_REM_W-1:0] : trial[lsvm_pkg::DIV_REM_W-1:0];
            word_next = {word_reg[lsvm_pkg::DIV_WORD_W-2:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == lsvm_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        word_reg    <= word_next;
        divisor_reg <= divisor_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = word_reg;

endmodule

// ===== src/linear_svm_sgd_trainer.sv =====
// pegasos linear svm trainer: sequencer, weight and sample memories, shared multiplier
// depends on lsvm_pkg and lsvm_div
//
// Words arrive one feature at a time; a read word returns one stored weight. After reset
// the block clears its whole weight memory, one entry a cycle, before it takes any word
// (configuration writes are taken throughout). A feature word in use passes the weight
// read, the shared multiplier and the accumulator; a read word passes the weight read and
// the result register to the output register. The feature word with last_feature set then
// starts the update pass, which walks every weight in use through one read, one multiply
// and one run of the shared bit-serial divider, two with the hinge term, and then finishes.
// One word is worked on at a time; a finished result waits in the output register.
module linear_svm_sgd_trainer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [lsvm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lsvm_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  lsvm_pkg::in_word_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output lsvm_pkg::out_word_t                 out_data
);

    typedef enum logic [14:0] {
        S_CLEAR     = 15'h0001,
        S_IDLE      = 15'h0002,
        S_RD_DATA   = 15'h0004,
        S_FT_MUL    = 15'h0008,
        S_FT_ACC    = 15'h0010,
        S_END_PREP  = 15'h0020,
        S_END_DEN   = 15'h0040,
        S_UP_RD     = 15'h0080,
        S_UP_MUL    = 15'h0100,
        S_UP_DIV1   = 15'h0200,
        S_UP_DIV1_W = 15'h0400,
        S_UP_DIV2_W = 15'h0800,
        S_UP_WR     = 15'h1000,
        S_FINISH    = 15'h2000,
        S_RESULT    = 15'h4000
    } state_t;

    state_t                           state_reg, state_next;
    logic [9:0]                       feature_count_reg, feature_count_next;
    logic [15:0]                      regularization_reg, regularization_next;
    logic [31:0]                      iter_reg, iter_next;
    logic signed [47:0]               acc_reg, acc_next;
    logic [lsvm_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic                             out_valid_reg, out_valid_next;
    lsvm_pkg::out_word_t              out_word_reg, out_word_next;

    lsvm_pkg::in_word_t               item_reg, item_next;
    lsvm_pkg::out_word_t              res_reg, res_next;
    logic signed [66:0]               prod_reg;
    logic [48:0]                      den_reg, den_next;
    logic                             hinge_reg, hinge_next;
    logic signed [31:0]               margin_reg, margin_next;
    logic signed [15:0]               xbuf_reg, xbuf_next;
    logic                             wneg_reg, wneg_next;
    logic signed [32:0]               scaled_reg, scaled_next;
    logic [35:0]                      mag_reg, mag_next;

    logic signed [31:0]               weight_mem [lsvm_pkg::MAX_FEATURES];
    logic signed [15:0]               sample_mem [lsvm_pkg::MAX_FEATURES];
    logic signed [31:0]               w_q_reg;
    logic signed [15:0]               sb_q_reg;
    logic [lsvm_pkg::ADDR_W-1:0]      rd_addr;
    logic                             w_we;
    logic [lsvm_pkg::ADDR_W-1:0]      w_waddr;
    logic signed [31:0]               w_wdata;
    logic                             sb_we;

    logic signed [32:0]               mul_a;
    logic signed [33:0]               mul_b;
    logic signed [66:0]               mul_p;

    lsvm_pkg::div_req_t               div_req;
    lsvm_pkg::div_rsp_t               div_rsp;

    logic [lsvm_pkg::CNT_W-1:0]       n_eff;
    logic                             accept;
    logic                             idx_in_use;
    logic [15:0]                      lam_eff;
    logic [32:0]                      t1;
    logic signed [47:0]               p48, q48;
    logic signed [48:0]               sum49, ydot49;
    logic [66:0]                      pabs;
    logic [16:0]                      xabs;
    logic [31:0]                      q32;
    logic                             tneg;
    logic signed [37:0]               term38, nw38;
    logic signed [31:0]               nw32;
    logic [lsvm_pkg::CNT_W-1:0]       cnt_inc;

    lsvm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign n_eff = (32'(feature_count_reg) > 32'(lsvm_pkg::MAX_FEATURES))
                   ? lsvm_pkg::CNT_W'(lsvm_pkg::MAX_FEATURES)
                   : lsvm_pkg::CNT_W'(feature_count_reg);
    assign in_stall   = (state_reg != S_IDLE);
    assign accept     = in_valid && !in_stall;
    assign idx_in_use = 32'(in_data.feature_index) < 32'(n_eff);
    assign lam_eff    = (regularization_reg == 16'd0) ? 16'd1 : regularization_reg;
    assign t1         = {1'b0, iter_reg} + 33'd1;
    assign mul_p      = mul_a * mul_b;
    assign cnt_inc    = cnt_reg + 1'b1;

    // dot product term, truncated toward zero
    assign p48   = prod_reg[47:0];
    assign q48   = (p48 + (p48[47] ? 48'sd4095 : 48'sd0)) >>> 12;
    assign sum49 = {acc_reg[47], acc_reg} + {q48[47], q48};
    assign ydot49 = item_reg.label ? {acc_reg[47], acc_reg} : -{acc_reg[47], acc_reg};

    assign pabs   = prod_reg[66] ? 67'(-prod_reg) : 67'(prod_reg);
    assign xabs   = xbuf_reg[15] ? 17'(-{xbuf_reg[15], xbuf_reg}) : 17'({1'b0, xbuf_reg});
    assign q32    = div_rsp.quotient[31:0];
    assign tneg   = xbuf_reg[15] ^ ~item_reg.label;
    assign term38 = tneg ? -$signed({2'b00, mag_reg}) : $signed({2'b00, mag_reg});
    assign nw38   = {{5{scaled_reg[32]}}, scaled_reg} + term38;
    assign nw32   = (nw38 > 38'sh007FFFFFFF) ? 32'sh7FFFFFFF
                  : (nw38 < -38'sh0080000000) ? 32'sh80000000 : nw38[31:0];

    always_comb
    begin
        state_next          = state_reg;
        feature_count_next  = feature_count_reg;
        regularization_next = regularization_reg;
        iter_next           = iter_reg;
        acc_next            = acc_reg;
        cnt_next            = cnt_reg;
        out_valid_next      = out_valid_reg;
        out_word_next       = out_word_reg;
        item_next           = item_reg;
        res_next            = res_reg;
        den_next            = den_reg;
        hinge_next          = hinge_reg;
        margin_next         = margin_reg;
        xbuf_next           = xbuf_reg;
        wneg_next           = wneg_reg;
        scaled_next         = scaled_reg;
        mag_next            = mag_reg;
        rd_addr             = lsvm_pkg::ADDR_W'(cnt_reg);
        w_we                = 1'b0;
        w_waddr             = lsvm_pkg::ADDR_W'(cnt_reg);
        w_wdata             = nw32;
        sb_we               = 1'b0;
        mul_a               = '0;
        mul_b               = '0;
        div_req             = '0;

        if (cfg_write)
        begin
            unique case (cfg_index)
                lsvm_pkg::CFG_FEATURE_COUNT:  feature_count_next  = cfg_data[9:0];
                lsvm_pkg::CFG_REGULARIZATION: regularization_next = cfg_data;
                default: ;
            endcase
        end

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_CLEAR:
            begin
                w_we    = 1'b1;
                w_wdata = '0;
                cnt_next = cnt_inc;
                if (cnt_inc == lsvm_pkg::CNT_W'(lsvm_pkg::MAX_FEATURES))
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                rd_addr = lsvm_pkg::ADDR_W'(in_data.feature_index);
                if (accept)
                begin
                    item_next = in_data;
                    if (in_data.kind == lsvm_pkg::KIND_READ)
                        state_next = S_RD_DATA;
                    else if (idx_in_use)
                    begin
                        sb_we      = 1'b1;
                        state_next = S_FT_MUL;
                    end
                    else if (in_data.last_feature)
                        state_next = S_END_PREP;
                end
            end
            S_RD_DATA:
            begin
                res_next.result_kind  = lsvm_pkg::RES_WEIGHT;
                res_next.weight_value = (32'(item_reg.feature_index) < 32'(lsvm_pkg::MAX_FEATURES))
                                        ? w_q_reg : 32'sd0;
                res_next.margin       = '0;
                res_next.hinge_active = 1'b0;
                res_next.samples_seen = iter_reg;
                state_next            = S_RESULT;
            end
            S_FT_MUL:
            begin
                mul_a      = {w_q_reg[31], w_q_reg};
                mul_b      = 34'(item_reg.feature_value);
                state_next = S_FT_ACC;
            end
            S_FT_ACC:
            begin
                if (sum49[48] != sum49[47])
                    acc_next = sum49[48] ? -48'sh7FFFFFFFFFFF - 48'sd1 : 48'sh7FFFFFFFFFFF;
                else
                    acc_next = sum49[47:0];
                state_next = item_reg.last_feature ? S_END_PREP : S_IDLE;
            end
            S_END_PREP:
            begin
                mul_a       = {17'd0, lam_eff};
                mul_b       = {1'b0, t1};
                hinge_next  = ydot49 < 49'sd16777216;
                margin_next = (ydot49 > 49'sh7FFFFFFF) ? 32'sh7FFFFFFF
                            : (ydot49 < -49'sh80000000) ? 32'sh80000000 : ydot49[31:0];
                state_next  = S_END_DEN;
            end
            S_END_DEN:
            begin
                den_next   = prod_reg[48:0];
                cnt_next   = '0;
                state_next = (n_eff == '0) ? S_FINISH : S_UP_RD;
            end
            S_UP_RD:
                state_next = S_UP_MUL;
            S_UP_MUL:
            begin
                mul_a      = {w_q_reg[31], w_q_reg};
                mul_b      = {2'b00, iter_reg};
                xbuf_next  = sb_q_reg;
                state_next = S_UP_DIV1;
            end
            S_UP_DIV1:
            begin
                wneg_next        = prod_reg[66];
                div_req.start    = 1'b1;
                div_req.steps    = lsvm_pkg::DIV_STEPS_SCALE;
                div_req.rem_init = lsvm_pkg::DIV_REM_W'(pabs[63:32]);
                div_req.dividend = {pabs[31:0], 32'd0};
                div_req.divisor  = lsvm_pkg::DIV_REM_W'(t1);
                state_next       = S_UP_DIV1_W;
            end
            S_UP_DIV1_W:
            begin
                if (div_rsp.done)
                begin
                    scaled_next = wneg_reg ? -$signed({1'b0, q32}) : $signed({1'b0, q32});
                    if (hinge_reg)
                    begin
                        div_req.start    = 1'b1;
                        div_req.steps    = lsvm_pkg::DIV_STEPS_TERM;
                        div_req.rem_init = '0;
                        div_req.dividend = {36'({xabs, 20'd0}), 28'd0};
                        div_req.divisor  = den_reg;
                        state_next       = S_UP_DIV2_W;
                    end
                    else
                    begin
                        mag_next   = '0;
                        state_next = S_UP_WR;
                    end
                end
            end
            S_UP_DIV2_W:
            begin
                if (div_rsp.done)
                begin
                    mag_next   = div_rsp.quotient[35:0];
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                w_we     = 1'b1;
                cnt_next = cnt_inc;
                state_next = (cnt_inc == n_eff) ? S_FINISH : S_UP_RD;
            end
            S_FINISH:
            begin
                iter_next = (iter_reg == 32'hFFFFFFFF) ? iter_reg : iter_reg + 32'd1;
                acc_next  = '0;
                res_next.result_kind  = lsvm_pkg::RES_SAMPLE;
                res_next.weight_value = '0;
                res_next.margin       = margin_reg;
                res_next.hinge_active = hinge_reg;
                res_next.samples_seen = iter_next;
                state_next            = S_RESULT;
            end
            S_RESULT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_word_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_CLEAR;
            feature_count_reg  <= 10'd512;
            regularization_reg <= 16'd256;
            iter_reg           <= '0;
            acc_reg            <= '0;
            cnt_reg            <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            state_reg          <= state_next;
            feature_count_reg  <= feature_count_next;
            regularization_reg <= regularization_next;
            iter_reg           <= iter_next;
            acc_reg            <= acc_next;
            cnt_reg            <= cnt_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        item_reg     <= item_next;
        res_reg      <= res_next;
        prod_reg     <= mul_p;
        den_reg      <= den_next;
        hinge_reg    <= hinge_next;
        margin_reg   <= margin_next;
        xbuf_reg     <= xbuf_next;
        wneg_reg     <= wneg_next;
        scaled_reg   <= scaled_next;
        mag_reg      <= mag_next;
    end

    // weight memory
    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[w_waddr] <= w_wdata;
        w_q_reg <= weight_mem[rd_addr];
    end

    // sample buffer
    always_ff @(posedge clk)
    begin
        if (sb_we)
            sample_mem[lsvm_pkg::ADDR_W'(in_data.feature_index)] <= in_data.feature_value;
        sb_q_reg <= sample_mem[rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_word_reg;

endmodule

// ===== src/lsvm_checker.sv =====
// port-level checks for the linear svm sgd trainer
// depends on lsvm_pkg; bound to linear_svm_sgd_trainer
module lsvm_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            cfg_write,
    input logic [lsvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [lsvm_pkg::CFG_DATA_W-1:0] cfg_data,
    input logic                            in_valid,
    input logic                            in_stall,
    input lsvm_pkg::in_word_t              in_data,
    input logic                            out_valid,
    input logic                            out_stall,
    input lsvm_pkg::out_word_t             out_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output word changed");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall
        && (in_data.kind == lsvm_pkg::KIND_READ || in_data.last_feature)
        |=> in_stall)
        else $error("input taken right after a read or end of sample");

    a_read_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lsvm_pkg::RES_WEIGHT
        |-> out_data.margin == 32'sd0 && !out_data.hinge_active)
        else $error("read word carries sample fields");

    a_report_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lsvm_pkg::RES_SAMPLE
        |-> out_data.weight_value == 32'sd0 && out_data.samples_seen != 32'd0)
        else $error("sample report malformed");

    a_hinge_margin: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == lsvm_pkg::RES_SAMPLE && !out_data.hinge_active
        |-> out_data.margin >= 32'sd16777216)
        else $error("hinge flag disagrees with margin");

endmodule

bind linear_svm_sgd_trainer lsvm_checker u_lsvm_checker (.*);

// ===== dv/lsvm_checker.sv =====
// checker for the linear svm sgd trainer: predicts every result from the accepted words
// and config writes, and compares the results field by field; depends on lsvm_pkg
module lsvm_scoreboard (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [lsvm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lsvm_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            in_valid,
    input  logic                            in_stall,
    input  lsvm_pkg::in_word_t              in_data,
    input  logic                            out_valid,
    input  logic                            out_stall,
    input  lsvm_pkg::out_word_t             out_data,
    output int                              errors,
    output int                              pending
);

    localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint ACC_LO = -ACC_HI - 1;
    localparam longint ONE_Q24 = 64'sd16777216;

    int                  weights [lsvm_pkg::MAX_FEATURES];
    logic signed [15:0]  sample_buf [lsvm_pkg::MAX_FEATURES];
    longint              dot_sum;
    logic [31:0]         trained;
    logic [9:0]          count_reg;
    logic [15:0]         lambda_reg;
    lsvm_pkg::out_word_t expected_words [$];

    function automatic int sat32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'sh8000_0000;
        return int'(v);
    endfunction

    task automatic train_step(input lsvm_pkg::in_word_t w);
        longint              n;
        longint              x;
        longint              prod;
        longint              ydot;
        longint              t;
        longint              t1;
        longint              den;
        longint              nw;
        longint              xv;
        longint              mag;
        bit                  pos;
        bit                  hinge;
        lsvm_pkg::out_word_t r;
        n = (count_reg > lsvm_pkg::MAX_FEATURES) ? lsvm_pkg::MAX_FEATURES : count_reg;
        r = '0;
        if (w.kind == lsvm_pkg::KIND_READ)
        begin
            r.result_kind  = lsvm_pkg::RES_WEIGHT;
            r.weight_value = weights[w.feature_index];
            r.samples_seen = trained;
            expected_words.push_back(r);
            return;
        end
        x = longint'(w.feature_value);
        if (w.feature_index < n)
        begin
            prod = (longint'(weights[w.feature_index]) * x) / 4096;
            dot_sum = dot_sum + prod;
            if (dot_sum > ACC_HI)
                dot_sum = ACC_HI;
            if (dot_sum < ACC_LO)
                dot_sum = ACC_LO;
            sample_buf[w.feature_index] = w.feature_value;
        end
        if (!w.last_feature)
            return;
        pos = w.label;
        ydot = pos ? dot_sum : -dot_sum;
        hinge = ydot < ONE_Q24;
        t = longint'(trained);
        t1 = t + 1;
        den = ((lambda_reg == 0) ? 64'sd1 : longint'(lambda_reg)) * t1;
        for (int i = 0; i < n; i++)
        begin
            nw = (longint'(weights[i]) * t) / t1;
            if (hinge)
            begin
                xv = longint'(sample_buf[i]);
                mag = ((xv < 0 ? -xv : xv) * 64'sd1048576) / den;
                nw = nw + ((((xv < 0) != !pos)) ? -mag : mag);
            end
            weights[i] = sat32(nw);
        end
        if (trained != 32'hFFFF_FFFF)
            trained = trained + 1;
        dot_sum = 0;
        r.result_kind  = lsvm_pkg::RES_SAMPLE;
        r.margin       = sat32(ydot);
        r.hinge_active = hinge;
        r.samples_seen = trained;
        expected_words.push_back(r);
    endtask

    task automatic check_word(input lsvm_pkg::out_word_t got);
        lsvm_pkg::out_word_t exp_w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: unexpected result word %h", $time, got);
            errors++;
            return;
        end
        exp_w = expected_words.pop_front();
        if (got.result_kind !== exp_w.result_kind)
        begin
            $display("%0t: result_kind expected %0d got %0d", $time, exp_w.result_kind,
                     got.result_kind);
            errors++;
        end
        if (got.weight_value !== exp_w.weight_value)
        begin
            $display("%0t: weight_value expected %0d got %0d", $time, exp_w.weight_value,
                     got.weight_value);
            errors++;
        end
        if (got.margin !== exp_w.margin)
        begin
            $display("%0t: margin expected %0d got %0d", $time, exp_w.margin, got.margin);
            errors++;
        end
        if (got.hinge_active !== exp_w.hinge_active)
        begin
            $display("%0t: hinge_active expected %0d got %0d", $time, exp_w.hinge_active,
                     got.hinge_active);
            errors++;
        end
        if (got.samples_seen !== exp_w.samples_seen)
        begin
            $display("%0t: samples_seen expected %0d got %0d", $time, exp_w.samples_seen,
                     got.samples_seen);
            errors++;
        end
    endtask

    initial
    begin
        errors = 0;
        pending = 0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (weights[i])
                weights[i] = 0;
            foreach (sample_buf[i])
                sample_buf[i] = '0;
            dot_sum = 0;
            trained = '0;
            count_reg = 10'd512;
            lambda_reg = 16'd256;
            expected_words.delete();
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == lsvm_pkg::CFG_FEATURE_COUNT)
                    count_reg = cfg_data[9:0];
                else if (cfg_index == lsvm_pkg::CFG_REGULARIZATION)
                    lambda_reg = cfg_data;
            end
            if (in_valid && !in_stall)
                train_step(in_data);
            if (out_valid && !out_stall)
                check_word(out_data);
        end
        pending = expected_words.size();
    end

endmodule

// ===== dv/linear_svm_sgd_trainer_tb.sv =====
// testbench top for the linear svm sgd trainer: clock, reset, stimulus and verdict
// depends on lsvm_pkg, linear_svm_sgd_trainer and lsvm_scoreboard
module linear_svm_sgd_trainer_tb;

    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 4000000;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_write;
    logic [lsvm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lsvm_pkg::CFG_DATA_W-1:0] cfg_data;
    logic                            in_valid;
    logic                            in_stall;
    lsvm_pkg::in_word_t              in_data;
    logic                            out_valid;
    logic                            out_stall;
    lsvm_pkg::out_word_t             out_data;
    int                              errors;
    int                              pending;

    int   cycles;
    int   words_sent;
    int   samples_sent;
    int   reads_sent;
    int   results_taken;
    int   cfg_writes;
    int   count_now;
    bit   quiet_in;
    bit   quiet_out;
    bit   written [lsvm_pkg::MAX_FEATURES];

    linear_svm_sgd_trainer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    lsvm_scoreboard u_scoreboard (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("[linear_svm_sgd_trainer] ERROR");
            $finish;
        end
    end

    function automatic logic [15:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_word(input lsvm_pkg::in_word_t w);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_data <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (w.kind == lsvm_pkg::KIND_READ)
            reads_sent++;
        else if (w.feature_index < count_now)
            written[w.feature_index] = 1'b1;
        if (w.kind == lsvm_pkg::KIND_FEATURE && w.last_feature)
            samples_sent++;
    endtask

    task automatic send_feature(input int idx, input logic [15:0] val, input bit lab,
                                input bit last);
        lsvm_pkg::in_word_t w;
        w.kind = lsvm_pkg::KIND_FEATURE;
        w.feature_index = 9'(idx);
        w.feature_value = val;
        w.label = lab;
        w.last_feature = last;
        send_word(w);
    endtask

    task automatic send_read(input int idx);
        lsvm_pkg::in_word_t w;
        w.kind = lsvm_pkg::KIND_READ;
        w.feature_index = 9'(idx);
        w.feature_value = 16'($urandom);
        w.label = 1'($urandom);
        w.last_feature = 1'($urandom);
        send_word(w);
    endtask

    task automatic send_sample(input bit broken);
        int order [$];
        int k;
        int j;
        int tmp;
        bit lab;
        for (int i = 0; i < count_now; i++)
            if (!(broken && written[i] && $urandom_range(0, 3) == 0))
                order.push_back(i);
        if (broken)
        begin
            repeat ($urandom_range(0, 2))
            begin
                if (count_now < lsvm_pkg::MAX_FEATURES)
                    order.push_back($urandom_range(count_now, lsvm_pkg::MAX_FEATURES - 1));
                else if (order.size() > 0)
                    order.push_back(order[$urandom_range(0, order.size() - 1)]);
            end
        end
        if (order.size() == 0)
            order.push_back(count_now < lsvm_pkg::MAX_FEATURES ?
                            $urandom_range(count_now, lsvm_pkg::MAX_FEATURES - 1) : 0);
        if (broken || $urandom_range(0, 3) == 0)
            for (k = order.size() - 1; k > 0; k--)
            begin
                j = $urandom_range(0, k);
                tmp = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
        lab = 1'($urandom);
        foreach (order[i])
            send_feature(order[i], pick_value(),
                         (i == order.size() - 1) ? lab : 1'($urandom),
                         i == order.size() - 1);
    endtask

    task automatic write_reg(input logic [lsvm_pkg::CFG_IDX_W-1:0] idx, input int value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= lsvm_pkg::CFG_DATA_W'(value);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        cfg_writes++;
        if (idx == lsvm_pkg::CFG_FEATURE_COUNT)
            count_now = (value > lsvm_pkg::MAX_FEATURES) ? lsvm_pkg::MAX_FEATURES : value;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    // receiver: random stall per word, with two long hold-offs
    initial
    begin
        int gap;
        out_stall = 1'b0;
        quiet_out = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (results_taken % 50 == 0)
                quiet_out = ($urandom_range(0, 3) == 0);
            if (results_taken == 100 || results_taken == 600)
                gap = 500;
            else
                gap = quiet_out ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            results_taken++;
            @(negedge clk);
        end
    end

    initial
    begin
        int phase;
        int phase_words;
        int phase_len;
        int pick;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        in_data = '0;
        cycles = 0;
        words_sent = 0;
        samples_sent = 0;
        reads_sent = 0;
        results_taken = 0;
        cfg_writes = 0;
        count_now = lsvm_pkg::MAX_FEATURES;
        quiet_in = 1'b0;
        foreach (written[i])
            written[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        write_reg(lsvm_pkg::CFG_FEATURE_COUNT, 4);
        write_reg(lsvm_pkg::CFG_REGULARIZATION, 256);
        send_feature(0, 16'h7FFF, 1'b0, 1'b0);
        send_feature(1, 16'h8000, 1'b0, 1'b0);
        send_feature(2, 16'h0000, 1'b0, 1'b0);
        send_feature(3, 16'h0001, 1'b1, 1'b1);
        send_read(0);
        send_read(1);
        send_read(511);
        send_feature(0, 16'h7FFF, 1'b1, 1'b0);
        send_feature(1, 16'h8000, 1'b1, 1'b0);
        send_feature(2, 16'h1000, 1'b1, 1'b0);
        send_feature(3, 16'hF000, 1'b0, 1'b1);
        send_feature(7, 16'h1234, 1'b1, 1'b1);
        settle();
        write_reg(lsvm_pkg::CFG_REGULARIZATION, 0);
        send_feature(2, 16'h7FFF, 1'b1, 1'b0);
        send_feature(0, 16'h8000, 1'b0, 1'b1);
        send_read(2);
        settle();
        write_reg(lsvm_pkg::CFG_REGULARIZATION, 65535);
        send_feature(1, 16'h4000, 1'b1, 1'b1);
        settle();
        write_reg(lsvm_pkg::CFG_FEATURE_COUNT, 0);
        send_feature(5, 16'h7FFF, 1'b1, 1'b1);
        send_read(3);
        settle();

        // random phases
        phase = 0;
        while (words_sent < ITEM_TARGET)
        begin
            if (phase == 3)
                write_reg(lsvm_pkg::CFG_FEATURE_COUNT, 512);
            else if (phase == 7)
                write_reg(lsvm_pkg::CFG_FEATURE_COUNT, 1023);
            else
                write_reg(lsvm_pkg::CFG_FEATURE_COUNT,
                          ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8));
            case ($urandom_range(0, 5))
                0: write_reg(lsvm_pkg::CFG_REGULARIZATION, 0);
                1: write_reg(lsvm_pkg::CFG_REGULARIZATION, 1);
                2: write_reg(lsvm_pkg::CFG_REGULARIZATION, 65535);
                3: write_reg(lsvm_pkg::CFG_REGULARIZATION, 256);
                default: write_reg(lsvm_pkg::CFG_REGULARIZATION, $urandom_range(1, 65535));
            endcase
            quiet_in = ($urandom_range(0, 3) == 0);
            if (count_now == lsvm_pkg::MAX_FEATURES)
            begin
                send_sample(1'b0);
                repeat (3) send_read($urandom_range(0, lsvm_pkg::MAX_FEATURES - 1));
            end
            else
            begin
                phase_words = words_sent;
                phase_len = $urandom_range(30, 80);
                while (words_sent - phase_words < phase_len)
                begin
                    pick = $urandom_range(0, 19);
                    if (pick < 13)
                        send_sample(1'b0);
                    else if (pick < 15)
                        send_sample(1'b1);
                    else if (pick < 18)
                        send_read(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                               : $urandom_range(0, 511));
                    else
                        send_feature($urandom_range(0, 511), pick_value(), 1'($urandom),
                                     1'b0);
                end
                // close any open sample before the pause
                send_sample(1'b0);
            end
            settle();
            phase++;
        end

        settle();
        repeat (200) @(negedge clk);
        $display("sent %0d words: %0d samples, %0d weight reads, %0d register writes",
                 words_sent, samples_sent, reads_sent, cfg_writes);
        $display("checked %0d results in %0d cycles", results_taken, cycles);
        if (errors == 0 && pending == 0)
            $display("[linear_svm_sgd_trainer] OK");
        else
            $display("[linear_svm_sgd_trainer] ERROR");
        $finish;
    end

endmodule

// ===== linear_svm_sgd_trainer.f =====
src/lsvm_pkg.sv
src/lsvm_div.sv
src/linear_svm_sgd_trainer.sv
src/lsvm_checker.sv
dv/lsvm_checker.sv
dv/linear_svm_sgd_trainer_tb.sv
